// ----- sv/pmfb_pkg.sv -----
// Shared types and codes for the paged monochrome frame store.
// No dependencies; imported by pmfb_geom, the top level and the testbench.
package pmfb_pkg;

   // Signed raw coordinate: holds start, end and clip limits of any run
   localparam int COORD_W = 11;
   // Byte count of a run: up to 511 columns
   localparam int SPAN_W  = 9;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_HLINE = 3'd1,
      CMD_VLINE = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_READ  = 3'd4
   } pmfb_cmd_type;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_SET    = 2'd1,
      MODE_INVERT = 2'd2,
      MODE_KEEP   = 2'd3
   } pmfb_mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_GEOM1,
      ST_GEOM2,
      ST_START,
      ST_RUN,
      ST_DRAIN,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } pmfb_state_type;

   // Raw run after rotation and clipping
   typedef struct packed {
      logic              clipped;
      logic              vert;       // run goes down one column
      logic [7:0]        col;        // first column
      logic [7:0]        row_first;  // first row
      logic [7:0]        row_last;   // last row (same as first for a row run)
      logic [SPAN_W-1:0] span;       // columns in a row run
   } pmfb_run_type;

endpackage

// ----- sv/pmfb_store.sv -----
// Frame store memory: one write port, one read port, registered read data.
// Depends on nothing.
module pmfb_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pmfb_geom.sv -----
// Two-stage geometry: rotation to raw coordinates, then clipping.
// Depends on pmfb_pkg. Stages load every cycle; caller waits for the run to pass both stages.
module pmfb_geom #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic [2:0]            command,
   input  logic [7:0]            pos_x,
   input  logic [7:0]            pos_y,
   input  logic [7:0]            line_length,
   input  logic [1:0]            rotation,
   output pmfb_pkg::pmfb_run_type run
);
   import pmfb_pkg::*;

   localparam logic signed [COORD_W-1:0] W_S   = COORD_W'(DISPLAY_WIDTH);
   localparam logic signed [COORD_W-1:0] H_S   = COORD_W'(DISPLAY_HEIGHT);
   localparam logic signed [COORD_W-1:0] ONE_S = COORD_W'(1);

   // stage 1: raw start point
   logic                      vert_ff, vert_in;
   logic signed [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [7:0]                len_ff, len_in;

   logic signed [COORD_W-1:0] xs, ys, ls;

   always_comb begin
      len_in = (command == CMD_PIXEL) ? 8'd1 : line_length;
      xs     = $signed(COORD_W'(pos_x));
      ys     = $signed(COORD_W'(pos_y));
      ls     = $signed(COORD_W'(len_in));
      vert_in = 1'b0;
      rx_in   = xs;
      ry_in   = ys;
      if (command == CMD_VLINE) begin
         case (rotation)
            2'd1: begin
               vert_in = 1'b0;
               rx_in   = W_S - ONE_S - ys - (ls - ONE_S);
               ry_in   = xs;
            end
            2'd2: begin
               vert_in = 1'b1;
               rx_in   = W_S - ONE_S - xs;
               ry_in   = H_S - ONE_S - ys - (ls - ONE_S);
            end
            2'd3: begin
               vert_in = 1'b0;
               rx_in   = ys;
               ry_in   = H_S - ONE_S - xs;
            end
            default: begin
               vert_in = 1'b1;
               rx_in   = xs;
               ry_in   = ys;
            end
         endcase
      end else begin
         case (rotation)
            2'd1: begin
               vert_in = 1'b1;
               rx_in   = W_S - ONE_S - ys;
               ry_in   = xs;
            end
            2'd2: begin
               vert_in = 1'b0;
               rx_in   = W_S - ONE_S - xs - (ls - ONE_S);
               ry_in   = H_S - ONE_S - ys;
            end
            2'd3: begin
               vert_in = 1'b1;
               rx_in   = ys;
               ry_in   = H_S - ONE_S - xs - (ls - ONE_S);
            end
            default: begin
               vert_in = 1'b0;
               rx_in   = xs;
               ry_in   = ys;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      vert_ff <= vert_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      len_ff  <= len_in;
   end

   // stage 2: clip along the run and across it
   pmfb_run_type              run_ff, run_in;
   logic signed [COORD_W-1:0] along, across, along_lim, across_lim;
   logic signed [COORD_W-1:0] a0, a1, a_end;

   always_comb begin
      along      = vert_ff ? ry_ff : rx_ff;
      across     = vert_ff ? rx_ff : ry_ff;
      along_lim  = vert_ff ? H_S : W_S;
      across_lim = vert_ff ? W_S : H_S;
      a0         = (along < 0) ? '0 : along;
      a_end      = along + $signed(COORD_W'(len_ff));
      a1         = (a_end > along_lim) ? along_lim : a_end;

      run_in.clipped = (across < 0) || (across >= across_lim) || (a1 <= a0);
      run_in.vert    = vert_ff;
      run_in.span    = SPAN_W'(a1 - a0);
      if (vert_ff) begin
         run_in.col       = across[7:0];
         run_in.row_first = a0[7:0];
         run_in.row_last  = 8'(a1 - ONE_S);
      end else begin
         run_in.col       = a0[7:0];
         run_in.row_first = across[7:0];
         run_in.row_last  = across[7:0];
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign run = run_ff;

endmodule

// ----- sv/paged_mono_framebuffer_draw.sv -----
// Top level of the paged monochrome frame store with pixel and line drawing.
// Depends on pmfb_pkg, pmfb_geom and pmfb_store.
//
// Frame store of DISPLAY_WIDTH columns by ceil(DISPLAY_HEIGHT/8) pages, one byte per
// column and page, bit n = row page*8+n, held in a single-port-read, single-port-write
// memory with registered read data. One request is worked on at a time and each
// gives one response. A pixel or line request passes through GEOM1, GEOM2 and START,
// then RUN for the n bytes touched (the run of columns of a row line, or the pages
// spanned by a column line), one byte read-modify-written per cycle through the
// memory, then DRAIN; a fully clipped line goes from START to DONE. Clear sweeps the
// store, a read request reads one byte, unused commands go to DONE. After reset a
// clearing pass over all STORE_SIZE bytes zeroes the store, with req_tready low
// throughout. Rotation is written through csr_wr_en at any time the block is idle.
// A finished response waits in the output register; the next request can be accepted meanwhile.
module paged_mono_framebuffer_draw #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] pos_x, [15:8] pos_y, [23:16] line_length, [25:24] draw_mode,
   // [35:26] read_address, [39:36] zero
   input  logic [39:0] req_tdata,
   // [2:0] command
   input  logic [2:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] clipped_away, [15:9] zero
   output logic [15:0] rsp_tdata,
   // rotation register
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import pmfb_pkg::*;

   localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(DISPLAY_WIDTH);

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   pmfb_state_type    state_ff, state_in;
   logic [1:0]        rot_ff;

   logic [2:0]        cmd_ff, cmd_in;
   logic [7:0]        x_ff, x_in, y_ff, y_in, len_ff, len_in;
   logic [1:0]        mode_ff, mode_in;
   logic [9:0]        raddr_ff, raddr_in;

   logic [ADDR_W-1:0] addr_ff, addr_in;        // next byte to read
   logic [SPAN_W-1:0] cnt_ff, cnt_in;          // bytes left in the run
   logic              first_ff, first_in;      // first byte of the run
   logic              clip_ff, clip_in;
   logic              rd_ok_ff, rd_ok_in;      // read address inside the store

   logic              wr_pend_ff, wr_pend_in;  // read issued, write due
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]        wr_mask_ff, wr_mask_in;

   logic [ADDR_W-1:0] sweep_ff, sweep_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_clip_ff, rsp_clip_in;

   // ------------------------------------------------------------------
   // submodules
   // ------------------------------------------------------------------
   pmfb_run_type      run;

   logic              st_rd_en, st_wr_en;
   logic [ADDR_W-1:0] st_rd_addr, st_wr_addr;
   logic [7:0]        st_rd_data, st_wr_data;

   pmfb_geom #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
   ) u_geom (
      .clock      (clock),
      .command    (cmd_ff),
      .pos_x      (x_ff),
      .pos_y      (y_ff),
      .line_length(len_ff),
      .rotation   (rot_ff),
      .run        (run)
   );

   pmfb_store #(
      .DEPTH (STORE_SIZE),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .rd_en  (st_rd_en),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data)
   );

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   logic       req_fire, rsp_free, sweep_last, run_last;
   logic [2:0] mask_lo, mask_hi;
   logic [7:0] run_mask;
   logic [4:0] page_first, page_last;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign sweep_last = (sweep_ff == LAST_ADDR);
   assign run_last   = (cnt_ff == SPAN_W'(1));
   assign page_first = run.row_first[7:3];
   assign page_last  = run.row_last[7:3];

   // partial masks at the ends of a column run; a row run sets a single bit
   always_comb begin
      mask_lo  = (first_ff || !run.vert) ? run.row_first[2:0] : 3'd0;
      mask_hi  = (run_last || !run.vert) ? run.row_last[2:0] : 3'd7;
      run_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:  if (sweep_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_PIXEL, CMD_HLINE, CMD_VLINE: state_in = ST_GEOM1;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_GEOM1: state_in = ST_GEOM2;
         ST_GEOM2: state_in = ST_START;
         ST_START: state_in = run.clipped ? ST_DONE : ST_RUN;
         ST_RUN:   if (run_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_CLEAR: if (sweep_last) state_in = ST_DONE;
         ST_READ:  state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // outputs and datapath
   // ------------------------------------------------------------------
   always_comb begin
      req_tready   = 1'b0;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      len_in       = len_ff;
      mode_in      = mode_ff;
      raddr_in     = raddr_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      clip_in      = clip_ff;
      rd_ok_in     = rd_ok_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_mask_in   = wr_mask_ff;
      sweep_in     = sweep_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = addr_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = wr_addr_ff;
      st_wr_data   = st_rd_data;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      // write-back half of the read-modify-write
      case (mode_ff)
         MODE_CLEAR:  st_wr_data = st_rd_data & ~wr_mask_ff;
         MODE_SET:    st_wr_data = st_rd_data | wr_mask_ff;
         MODE_INVERT: st_wr_data = st_rd_data ^ wr_mask_ff;
         default:     st_wr_data = st_rd_data;
      endcase
      if (wr_pend_ff) begin
         st_wr_en = 1'b1;
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = sweep_ff;
            st_wr_data = 8'h00;
            sweep_in   = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd_in     = req_tuser;
            x_in       = req_tdata[7:0];
            y_in       = req_tdata[15:8];
            len_in     = req_tdata[23:16];
            mode_in    = req_tdata[25:24];
            raddr_in   = req_tdata[35:26];
            clip_in    = 1'b0;
            rd_ok_in   = (32'(req_tdata[35:26]) < STORE_SIZE);
         end
         ST_START: begin
            clip_in  = run.clipped;
            first_in = 1'b1;
            addr_in  = ADDR_W'(int'(page_first) * DISPLAY_WIDTH + int'(run.col));
            cnt_in   = run.vert ? SPAN_W'(page_last - page_first) + SPAN_W'(1) : run.span;
         end
         ST_RUN: begin
            st_rd_en   = 1'b1;
            st_rd_addr = addr_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = addr_ff;
            wr_mask_in = run_mask;
            first_in   = 1'b0;
            cnt_in     = cnt_ff - SPAN_W'(1);
            addr_in    = addr_ff + (run.vert ? ROW_STEP : ADDR_W'(1));
         end
         ST_READ: begin
            st_rd_en   = 1'b1;
            st_rd_addr = ADDR_W'(raddr_ff);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (cmd_ff == CMD_READ && rd_ok_ff) ? st_rd_data : 8'h00;
               rsp_clip_in  = clip_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rot_ff       <= 2'd0;
         sweep_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rot_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      len_ff      <= len_in;
      mode_ff     <= mode_in;
      raddr_ff    <= raddr_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      first_ff    <= first_in;
      clip_ff     <= clip_in;
      rd_ok_ff    <= rd_ok_in;
      wr_addr_ff  <= wr_addr_in;
      wr_mask_ff  <= wr_mask_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_clip_ff, rsp_data_ff};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // read and write-back never meet on one byte
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (st_rd_en && st_wr_en) |-> (st_rd_addr != st_wr_addr))
      else $error("read and write to the same byte in one cycle");

   // the store is only written while sweeping or finishing a run
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> (state_ff == ST_INIT || state_ff == ST_CLEAR ||
                    state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("store written outside a sweep or run");

   // a pending write-back always follows a run cycle
   a_wr_follows_run: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff) == ST_RUN)
      else $error("write-back without a preceding read");

   // run never starts or continues with an empty count
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff != '0))
      else $error("run with zero bytes left");

endmodule

// ----- test/paged_mono_framebuffer_draw_tb.sv -----
// Self-checking testbench for paged_mono_framebuffer_draw: drawing, clear and read requests.
// Depends on pmfb_pkg and the block's RTL; it keeps its own shadow of the frame store.
`timescale 1ns / 1ps

module paged_mono_framebuffer_draw_tb;
   import pmfb_pkg::*;

   // Geometry of the instance under test (default parameters)
   localparam int DISP_W      = 128;
   localparam int DISP_H      = 64;
   localparam int PAGES       = (DISP_H + 7) / 8;
   localparam int STORE_BYTES = DISP_W * PAGES;

   // Rotation register values
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Command codes with no meaning: the block answers them with zeros
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // Cycles with no handshake on either channel before the run is abandoned.
   // Worst case: the clearing pass after reset or a clear request, plus a long
   // receiver stall.
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_PER_PHASE = 212;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] line_length;
      logic [1:0] draw_mode;
      logic [9:0] read_address;
   } draw_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } draw_rsp_type;

   logic        clock        = 1'b1;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata    = '0;
   logic [2:0]  req_tuser    = '0;
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en    = 1'b0;
   logic [1:0]  csr_wr_data  = '0;

   // Stimulus and scoreboard
   draw_req_type draw_queue[$];     // requests not yet offered
   draw_rsp_type expected_rsp[$];   // predictions for accepted requests, oldest first
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int          error_count    = 0;
   int          quiet_cycles   = 0;

   // Shadow of the block's state
   logic [7:0]  shadow_store [STORE_BYTES];
   logic [1:0]  shadow_rotation = ROT_0;

   draw_rsp_type got_expect;
   draw_req_type seen_req;
   draw_req_type drive_req;

   paged_mono_framebuffer_draw dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------------
   // Shadow frame store
   // ---------------------------------------------------------------------------

   // Read-modify-write of one byte; indices off the store are dropped
   function automatic void touch_byte(int idx, logic [7:0] mask, logic [1:0] mode);
      if (idx < 0 || idx >= STORE_BYTES)
         return;
      case (mode)
         MODE_CLEAR:  shadow_store[idx] = shadow_store[idx] & ~mask;
         MODE_SET:    shadow_store[idx] = shadow_store[idx] | mask;
         MODE_INVERT: shadow_store[idx] = shadow_store[idx] ^ mask;
         default: ;
      endcase
   endfunction

   // Raw run along one row; returns 1 when nothing of it is on the panel
   function automatic bit row_run(int x, int y, int len, logic [1:0] mode);
      int x0;
      int x1;
      int c;
      if (y < 0 || y >= DISP_H)
         return 1'b1;
      x0 = (x < 0) ? 0 : x;
      x1 = x + len;
      if (x1 > DISP_W)
         x1 = DISP_W;
      if (x1 <= x0)
         return 1'b1;
      for (c = x0; c < x1; c++)
         touch_byte(c + (y / 8) * DISP_W, 8'(1 << (y % 8)), mode);
      return 1'b0;
   endfunction

   // Raw run down one column: partial masks at the ends, whole bytes between
   function automatic bit column_run(int x, int y, int len, logic [1:0] mode);
      int y0;
      int y1;
      int p;
      int base;
      int lo;
      int hi;
      int mask;
      if (x < 0 || x >= DISP_W)
         return 1'b1;
      y0 = (y < 0) ? 0 : y;
      y1 = y + len;
      if (y1 > DISP_H)
         y1 = DISP_H;
      if (y1 <= y0)
         return 1'b1;
      for (p = y0 / 8; p <= (y1 - 1) / 8; p++) begin
         base = p * 8;
         lo   = ((y0 > base) ? y0 : base) - base;
         hi   = ((y1 < base + 8) ? y1 : base + 8) - base;
         mask = ((1 << hi) - 1) & ~((1 << lo) - 1);
         touch_byte(x + p * DISP_W, mask[7:0], mode);
      end
      return 1'b0;
   endfunction

   // Line toward larger x in the rotated frame
   function automatic bit draw_row(int x, int y, int len, logic [1:0] mode);
      case (shadow_rotation)
         ROT_90:  return column_run(DISP_W - 1 - y, x, len, mode);
         ROT_180: return row_run(DISP_W - 1 - x - (len - 1), DISP_H - 1 - y, len, mode);
         ROT_270: return column_run(y, DISP_H - 1 - x - (len - 1), len, mode);
         default: return row_run(x, y, len, mode);
      endcase
   endfunction

   // Line toward larger y in the rotated frame
   function automatic bit draw_column(int x, int y, int len, logic [1:0] mode);
      case (shadow_rotation)
         ROT_90:  return row_run(DISP_W - 1 - y - (len - 1), x, len, mode);
         ROT_180: return column_run(DISP_W - 1 - x, DISP_H - 1 - y - (len - 1), len, mode);
         ROT_270: return row_run(y, DISP_H - 1 - x, len, mode);
         default: return column_run(x, y, len, mode);
      endcase
   endfunction

   // Applies one request to the shadow store and gives the response it should cause
   function automatic draw_rsp_type predict_draw(draw_req_type r);
      draw_rsp_type o;
      int        i;
      o = '0;
      case (r.command)
         CMD_PIXEL: o.clipped = draw_row(r.pos_x, r.pos_y, 1, r.draw_mode);
         CMD_HLINE: o.clipped = draw_row(r.pos_x, r.pos_y, r.line_length, r.draw_mode);
         CMD_VLINE: o.clipped = draw_column(r.pos_x, r.pos_y, r.line_length, r.draw_mode);
         CMD_CLEAR: begin
            for (i = 0; i < STORE_BYTES; i++)
               shadow_store[i] = 8'h00;
         end
         CMD_READ: begin
            if (r.read_address < STORE_BYTES)
               o.read_data = shadow_store[r.read_address];
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic queue_req(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                            logic [7:0] len, logic [1:0] mode, logic [9:0] addr);
      draw_req_type r;
      r.command      = cmd;
      r.pos_x        = x;
      r.pos_y        = y;
      r.line_length  = len;
      r.draw_mode    = mode;
      r.read_address = addr;
      draw_queue.push_back(r);
   endtask

   // Mostly on the visible panel, now and then anywhere in the 8-bit range
   function automatic logic [7:0] pick_coord(int span);
      if ($urandom_range(9) < 8)
         return 8'($urandom_range(span - 1));
      return 8'($urandom_range(255));
   endfunction

   function automatic draw_req_type random_request();
      draw_req_type r;
      int        vis_w;
      int        vis_h;
      int        pick;
      int        len_pick;
      vis_w = shadow_rotation[0] ? DISP_H : DISP_W;
      vis_h = shadow_rotation[0] ? DISP_W : DISP_H;
      pick  = $urandom_range(99);
      r.pos_x        = pick_coord(vis_w);
      r.pos_y        = pick_coord(vis_h);
      r.draw_mode    = 2'($urandom_range(3));
      r.read_address = 10'($urandom_range(STORE_BYTES - 1));
      len_pick       = $urandom_range(9);
      if (len_pick < 5)
         r.line_length = 8'($urandom_range(16));
      else if (len_pick < 8)
         r.line_length = 8'($urandom_range(vis_w > vis_h ? vis_w : vis_h));
      else
         r.line_length = 8'($urandom_range(255));
      if (pick < 30)
         r.command = CMD_PIXEL;
      else if (pick < 55)
         r.command = CMD_HLINE;
      else if (pick < 75)
         r.command = CMD_VLINE;
      else if (pick < 95)
         r.command = CMD_READ;
      else if (pick < 96)
         r.command = CMD_CLEAR;
      else if (pick < 98)
         r.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else
         r = draw_req_type'({$urandom, $urandom});  // every field anywhere in range
      return r;
   endfunction

   // Wait until every request has been taken and answered
   task automatic wait_drained();
      while (draw_queue.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: one request offered at a time from draw_queue
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (draw_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_req = draw_queue.pop_front();
            req_tdata  <= {4'b0, drive_req.read_address, drive_req.draw_mode,
                           drive_req.line_length, drive_req.pos_y, drive_req.pos_x};
            req_tuser  <= drive_req.command;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each accepted response.
   // The response is looked at first; it always belongs to an earlier request.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding: expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               got_expect = expected_rsp.pop_front();
               if (rsp_tdata[7:0] !== got_expect.read_data) begin
                  $display("%0t: read_data mismatch: expected %h, actual %h",
                           $time, got_expect.read_data, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[8] !== got_expect.clipped) begin
                  $display("%0t: clipped_away mismatch: expected %b, actual %b",
                           $time, got_expect.clipped, rsp_tdata[8]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen_req.command      = req_tuser;
            seen_req.pos_x        = req_tdata[7:0];
            seen_req.pos_y        = req_tdata[15:8];
            seen_req.line_length  = req_tdata[23:16];
            seen_req.draw_mode    = req_tdata[25:24];
            seen_req.read_address = req_tdata[35:26];
            expected_rsp.push_back(predict_draw(seen_req));
         end
      end
   end

   // Watchdog: too long without any handshake means the block has hung
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("paged_mono_framebuffer_draw_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed requests, then phases of random requests
   // ---------------------------------------------------------------------------
   logic [1:0] phase_rotation [8] = '{ROT_270, ROT_90, ROT_0, ROT_180,
                                      ROT_270, ROT_0, ROT_90, ROT_180};

   initial begin
      int p;
      int n;
      for (n = 0; n < STORE_BYTES; n++)
         shadow_store[n] = 8'h00;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: store reads zero after reset, corner pixels, clipping cases
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd0);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd1023);
      queue_req(CMD_PIXEL, 8'd0,   8'd0,   8'd0,   MODE_SET,    10'd0);
      queue_req(CMD_PIXEL, 8'd127, 8'd63,  8'd0,   MODE_SET,    10'd0);
      queue_req(CMD_PIXEL, 8'd255, 8'd255, 8'd255, MODE_SET,    10'd0);   // off panel
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd0);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd1023);
      queue_req(CMD_HLINE, 8'd10,  8'd10,  8'd0,   MODE_SET,    10'd0);   // zero length
      queue_req(CMD_HLINE, 8'd0,   8'd5,   8'd255, MODE_SET,    10'd0);   // runs off the right
      queue_req(CMD_HLINE, 8'd120, 8'd5,  8'd20,  MODE_INVERT, 10'd0);
      queue_req(CMD_VLINE, 8'd40,  8'd3,   8'd20,  MODE_SET,    10'd0);   // partial end masks
      queue_req(CMD_VLINE, 8'd200, 8'd0,   8'd10,  MODE_SET,    10'd0);   // column off panel
      queue_req(CMD_VLINE, 8'd40,  8'd0,   8'd255, MODE_KEEP,   10'd0);   // no change
      queue_req(CMD_VLINE, 8'd40,  8'd8,   8'd8,   MODE_CLEAR,  10'd0);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd40);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd168);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd125);
      queue_req(CMD_SPARE_LO, 8'hff, 8'hff, 8'hff, MODE_SET,    10'h3ff);
      queue_req(3'd6,      8'h55,  8'haa,  8'h55,  MODE_INVERT, 10'h2aa);
      queue_req(CMD_SPARE_HI, 8'hff, 8'hff, 8'hff, MODE_KEEP,   10'h3ff);
      queue_req(CMD_CLEAR, 8'hff,  8'hff,  8'hff,  MODE_INVERT, 10'h3ff);
      queue_req(CMD_READ,  8'd0,   8'd0,   8'd0,   MODE_KEEP,   10'd5);
      wait_drained();

      // Random phases: each sets a rotation and an idling pattern
      for (p = 0; p < 8; p++) begin
         repeat (8) @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_rotation[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         shadow_rotation = phase_rotation[p];
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE / 2; n++)
            draw_queue.push_back(random_request());
         // hold off the sender until every response so far is back
         wait_drained();
         for (n = 0; n < RANDOM_PER_PHASE / 2; n++)
            draw_queue.push_back(random_request());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("paged_mono_framebuffer_draw_tb passed");
      else
         $display("paged_mono_framebuffer_draw_tb failed");
      $finish;
   end

endmodule
